### hw/rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// shared types, constants and arithmetic helpers of the rmsprop update block
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int unsigned ELEMENTS_DEF = 4096;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [CFG_W-1:0] LR_RST    = 16'd655;
  localparam logic [CFG_W-1:0] ALPHA_RST = 16'd64880;
  localparam logic [CFG_W-1:0] EPS_RST   = 16'd1;
  localparam logic [CFG_W-1:0] WD_RST    = 16'd0;
  localparam logic [CFG_W-1:0] MOM_RST   = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE   = 3'd0,
    REG_DECAY_ALPHA  = 3'd1,
    REG_EPSILON      = 3'd2,
    REG_WD_FACTOR    = 3'd3,
    REG_MOMENTUM     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] learn_rate;
    logic [CFG_W-1:0] decay_alpha;
    logic [CFG_W-1:0] epsilon;
    logic [CFG_W-1:0] wd_factor;
    logic [CFG_W-1:0] momentum_factor;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] grad;
    logic signed [DATA_W-1:0] param;
  } item_t;

  // payload that rides along the back pipeline
  typedef struct packed {
    logic signed [DATA_W-1:0] param;
    logic                     neg;
    logic [DATA_W-1:0]        mag;
    logic signed [32:0]       mom_term;
  } pl_t;

  typedef struct packed {
    logic [47:0] rad;
    logic [25:0] rem;
    logic [23:0] root;
  } sq_t;

  typedef struct packed {
    logic [30:0] num;
    logic [24:0] rem;
    logic [24:0] den;
    logic [30:0] q;
    logic        ovf;
  } dv_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] != {3{v[33]}}) begin
      return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // one result bit of the integer square root
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t        n;
    logic [27:0] r2;
    logic [27:0] tr;
    r2 = {s.rem, s.rad[47:46]};
    tr = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[45:0], 2'b00};
    if (r2 >= tr) begin
      n.rem  = 26'(r2 - tr);
      n.root = {s.root[22:0], 1'b1};
    end else begin
      n.rem  = r2[25:0];
      n.root = {s.root[22:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of the restoring divider
  function automatic dv_t div_step(input dv_t d);
    dv_t        n;
    logic [25:0] r2;
    r2 = {d.rem, d.num[30]};
    n = d;
    n.num = {d.num[29:0], 1'b0};
    if (r2 >= {1'b0, d.den}) begin
      n.rem = 25'(r2 - {1'b0, d.den});
      n.q   = {d.q[29:0], 1'b1};
    end else begin
      n.rem = r2[24:0];
      n.q   = {d.q[29:0], 1'b0};
    end
    return n;
  endfunction

endpackage

### hw/rtl/rmsprop_update.sv
// ----------------------------------------------------------------------------
// rmsprop_update
// rmsprop parameter update with weight decay and momentum, q16.16 fixed point
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) takes elem_index, gradient, param_value;
// output channel (out_valid/out_ready) returns new_param, one per transaction,
// in input order. configuration is written through cfg_we/cfg_addr/cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
// new_param is registered at the end of the back pipeline, which holds the
// 24-stage square root and the 31-stage divider.
// throughput is one transaction per cycle while the output does not stall; an
// item whose index matches one still in flight before its momentum write waits
// in the two-entry issue queue until that one leaves the momentum stage.
// after reset both stores are swept to zero, one entry per cycle, with
// in_ready low until the sweep ends; config registers return to their defaults.
// when out_valid is high and out_ready is low the whole back pipeline holds;
// the queue keeps taking input until it is full, then in_ready drops.
// ----------------------------------------------------------------------------
module rmsprop_update #(
  parameter int unsigned ELEMENTS = rsp_pkg::ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rsp_pkg::IDX_W-1:0]          elem_index,
  input  logic signed [rsp_pkg::DATA_W-1:0]  gradient,
  input  logic signed [rsp_pkg::DATA_W-1:0]  param_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rsp_pkg::DATA_W-1:0]  new_param,
  input  logic                               cfg_we,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [rsp_pkg::CFG_W-1:0]          cfg_wdata
);
  import rsp_pkg::*;

  localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  cfg_t          cfg;
  logic          iss_valid;
  logic          iss_ready;
  logic [AW-1:0] iss_idx;
  item_t         iss_item;
  logic          clr_en;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{learn_rate: LR_RST, decay_alpha: ALPHA_RST, epsilon: EPS_RST,
               wd_factor: WD_RST, momentum_factor: MOM_RST};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LEARN_RATE:   cfg.learn_rate      <= cfg_wdata;
        REG_DECAY_ALPHA:  cfg.decay_alpha     <= cfg_wdata;
        REG_EPSILON:      cfg.epsilon         <= cfg_wdata;
        REG_WD_FACTOR:    cfg.wd_factor       <= cfg_wdata;
        REG_MOMENTUM:     cfg.momentum_factor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rsp_front #(.ELEMENTS(ELEMENTS), .AW(AW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .elem_index  (elem_index),
    .gradient    (gradient),
    .param_value (param_value),
    .iss_valid   (iss_valid),
    .iss_ready   (iss_ready),
    .iss_idx     (iss_idx),
    .iss_item    (iss_item),
    .clr_en      (clr_en),
    .clr_addr    (clr_addr)
  );

  rsp_back #(.ELEMENTS(ELEMENTS), .AW(AW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss_idx   (iss_idx),
    .iss_item  (iss_item),
    .clr_en    (clr_en),
    .clr_addr  (clr_addr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_param (new_param)
  );

  a_no_issue_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(iss_valid && iss_ready))
    else $error("issue while output stalled");

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_en |-> (!in_ready && !iss_valid))
    else $error("traffic during clearing sweep");

  a_clear_after_reset: assert property (@(posedge clk)
    (rst && !$past(rst)) |=> clr_en)
    else $error("clearing sweep did not start after reset");

endmodule

### hw/rtl/rsp_ram.sv
// ----------------------------------------------------------------------------
// rsp_ram
// single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front
// input acceptance, index wrap, issue queue and post-reset clearing sweep
// ----------------------------------------------------------------------------
module rsp_front #(
  parameter int unsigned ELEMENTS = 4096,
  parameter int unsigned AW       = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rsp_pkg::IDX_W-1:0]        elem_index,
  input  logic signed [rsp_pkg::DATA_W-1:0] gradient,
  input  logic signed [rsp_pkg::DATA_W-1:0] param_value,
  output logic                             iss_valid,
  input  logic                             iss_ready,
  output logic [AW-1:0]                    iss_idx,
  output rsp_pkg::item_t                   iss_item,
  output logic                             clr_en,
  output logic [AW-1:0]                    clr_addr
);
  import rsp_pkg::*;

  localparam logic [AW:0] CNT_END = (AW+1)'(ELEMENTS);

  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if ((longint'(ELEMENTS) << k) <= longint'(r)) begin
        r = r - IDX_W'(longint'(ELEMENTS) << k);
      end
    end
    return AW'(r);
  endfunction

  logic [AW:0]   clr_cnt;
  item_t         qi [0:1];
  logic [AW-1:0] qx [0:1];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  logic          push;
  logic          pop;

  assign clr_en   = (clr_cnt != CNT_END);
  assign clr_addr = clr_cnt[AW-1:0];

  assign in_ready  = !clr_en && (cnt != 2'd2);
  assign push      = in_valid && in_ready;
  assign iss_valid = (cnt != 2'd0);
  assign pop       = iss_valid && iss_ready;
  assign iss_idx   = qx[rp];
  assign iss_item  = qi[rp];
  assign cnt_next  = cnt + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      wp      <= 1'b0;
      rp      <= 1'b0;
      cnt     <= '0;
    end else begin
      if (clr_en) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qx[wp] <= wrap_idx(elem_index);
      qi[wp] <= '{grad: gradient, param: param_value};
    end
  end

endmodule

### hw/rtl/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back
// update pipeline: decay, square average, root, divide, momentum, step
// ----------------------------------------------------------------------------
module rsp_back #(
  parameter int unsigned ELEMENTS = 4096,
  parameter int unsigned AW       = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rsp_pkg::cfg_t                     cfg,
  input  logic                              iss_valid,
  output logic                              iss_ready,
  input  logic [AW-1:0]                     iss_idx,
  input  rsp_pkg::item_t                    iss_item,
  input  logic                              clr_en,
  input  logic [AW-1:0]                     clr_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rsp_pkg::DATA_W-1:0] new_param
);
  import rsp_pkg::*;

  localparam int unsigned NS    = 63;
  localparam int unsigned S_AVG = 2;
  localparam int unsigned S_MOM = 60;
  localparam int unsigned SQ_N  = 24;
  localparam int unsigned DV_N  = 31;

  logic            adv;
  logic            conflict;
  logic            take;
  logic [NS-1:0]   vld;
  logic [AW-1:0]   ix [0:S_MOM];

  logic [31:0]     sa_rdata;
  logic [31:0]     mb_rdata;
  logic            sa_we;
  logic [AW-1:0]   sa_waddr;
  logic [31:0]     sa_wdata;
  logic            mb_we;
  logic [AW-1:0]   mb_waddr;
  logic [31:0]     mb_wdata;

  item_t              s0_item;
  logic signed [48:0] wdp;
  logic signed [33:0] gsum;
  logic signed [31:0] g_s0;
  logic [31:0]        mag_s0;

  logic               s1_neg;
  logic [31:0]        s1_mag;
  logic signed [31:0] s1_param;
  logic [31:0]        s1_avg_old;
  logic signed [31:0] s1_mom_old;
  logic [63:0]        gsq_full;
  logic [31:0]        gsq_s1;
  logic signed [48:0] mom_prod;

  logic [31:0]        s2_gsq;
  logic [31:0]        s2_avg_old;
  logic [47:0]        avg_pa;
  logic [48:0]        avg_pb;
  logic [49:0]        avg_sum;
  logic [31:0]        avg_s2;

  pl_t                pl [S_AVG:NS-1];
  sq_t                sq [0:SQ_N];
  dv_t                dv [0:DV_N];
  dv_t                dv_init;
  logic [24:0]        den_raw;

  logic signed [31:0] step_s59;
  logic signed [31:0] s60_step;
  logic signed [31:0] buf_s60;
  logic signed [31:0] x_s60;
  logic signed [31:0] s61_x;
  logic signed [48:0] lprod;
  logic signed [32:0] s62_lsh;

  assign adv = !out_valid || out_ready;

  always_comb begin
    conflict = 1'b0;
    for (int k = 0; k <= S_MOM; k++) begin
      if (vld[k] && (ix[k] == iss_idx)) begin
        conflict = 1'b1;
      end
    end
  end

  assign iss_ready = adv && !conflict;
  assign take      = iss_valid && iss_ready;

  // stage 0: weight decay
  assign wdp    = $signed({1'b0, cfg.wd_factor}) * s0_item.param;
  assign gsum   = {{2{s0_item.grad[31]}}, s0_item.grad} + {wdp[48], wdp[48:16]};
  assign g_s0   = sat34(gsum);
  assign mag_s0 = g_s0[31] ? (~g_s0 + 32'd1) : g_s0;

  // stage 1: gradient square and momentum decay
  assign gsq_full = s1_mag * s1_mag;
  assign gsq_s1   = (gsq_full[63:48] != 16'd0) ? 32'hFFFF_FFFF : gsq_full[47:16];
  assign mom_prod = $signed({1'b0, cfg.momentum_factor}) * s1_mom_old;

  // stage 2: square average
  assign avg_pa  = cfg.decay_alpha * s2_avg_old;
  assign avg_pb  = (17'h10000 - {1'b0, cfg.decay_alpha}) * s2_gsq;
  assign avg_sum = {2'b00, avg_pa} + {1'b0, avg_pb};
  assign avg_s2  = (avg_sum[49:48] != 2'd0) ? 32'hFFFF_FFFF : avg_sum[47:16];

  // end of root: denominator and overflow check
  always_comb begin
    den_raw     = {1'b0, sq[SQ_N].root} + {9'd0, cfg.epsilon};
    dv_init.den = (den_raw == 25'd0) ? 25'd1 : den_raw;
    dv_init.rem = {8'd0, pl[S_AVG+SQ_N+1].mag[31:15]};
    dv_init.num = {pl[S_AVG+SQ_N+1].mag[14:0], 16'd0};
    dv_init.q   = '0;
    dv_init.ovf = (dv_init.rem >= dv_init.den);
  end

  always_comb begin
    if (dv[DV_N].ovf) begin
      step_s59 = pl[S_MOM-1].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      step_s59 = pl[S_MOM-1].neg ? -$signed({1'b0, dv[DV_N].q}) : $signed({1'b0, dv[DV_N].q});
    end
  end

  assign buf_s60 = sat34({pl[S_MOM].mom_term[32], pl[S_MOM].mom_term}
                       + {{2{s60_step[31]}}, s60_step});
  assign x_s60   = (cfg.momentum_factor != '0) ? buf_s60 : s60_step;
  assign lprod   = $signed({1'b0, cfg.learn_rate}) * s61_x;

  assign sa_we    = clr_en || (adv && vld[S_AVG]);
  assign sa_waddr = clr_en ? clr_addr : ix[S_AVG];
  assign sa_wdata = clr_en ? 32'd0 : avg_s2;
  assign mb_we    = clr_en || (adv && vld[S_MOM] && (cfg.momentum_factor != '0));
  assign mb_waddr = clr_en ? clr_addr : ix[S_MOM];
  assign mb_wdata = clr_en ? 32'd0 : buf_s60;

  rsp_ram #(.WIDTH(32), .DEPTH(ELEMENTS), .AW(AW)) u_sq_avg (
    .clk   (clk),
    .we    (sa_we),
    .waddr (sa_waddr),
    .wdata (sa_wdata),
    .re    (adv),
    .raddr (iss_idx),
    .rdata (sa_rdata)
  );

  rsp_ram #(.WIDTH(32), .DEPTH(ELEMENTS), .AW(AW)) u_mom_buf (
    .clk   (clk),
    .we    (mb_we),
    .waddr (mb_waddr),
    .wdata (mb_wdata),
    .re    (adv),
    .raddr (iss_idx),
    .rdata (mb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NS-2:0], take};
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= iss_item;
      ix[0]   <= iss_idx;
      for (int k = 0; k < S_MOM; k++) begin
        ix[k+1] <= ix[k];
      end
      s1_neg     <= g_s0[31];
      s1_mag     <= mag_s0;
      s1_param   <= s0_item.param;
      s1_avg_old <= sa_rdata;
      s1_mom_old <= mb_rdata;
      s2_gsq     <= gsq_s1;
      s2_avg_old <= s1_avg_old;
      pl[S_AVG]  <= '{param: s1_param, neg: s1_neg, mag: s1_mag,
                      mom_term: mom_prod[48:16]};
      for (int k = S_AVG; k < NS - 1; k++) begin
        pl[k+1] <= pl[k];
      end
      sq[0] <= '{rad: {avg_s2, 16'd0}, rem: '0, root: '0};
      for (int k = 0; k < SQ_N; k++) begin
        sq[k+1] <= sqrt_step(sq[k]);
      end
      dv[0] <= dv_init;
      for (int k = 0; k < DV_N; k++) begin
        dv[k+1] <= div_step(dv[k]);
      end
      s60_step  <= step_s59;
      s61_x     <= x_s60;
      s62_lsh   <= lprod[48:16];
      new_param <= sat34({{2{pl[NS-1].param[31]}}, pl[NS-1].param}
                       - {s62_lsh[32], s62_lsh});
    end
  end

endmodule

### sim/rmsprop_update_test.sv
// ----------------------------------------------------------------------------
// rmsprop_update_test
// self-checking bench: drives random and corner-case transactions through
// rmsprop_update under several config settings and handshake stall patterns,
// and compares each new_param against a bit-exact fixed-point model
// ----------------------------------------------------------------------------
module rmsprop_update_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rsp_pkg::*;

  class update_scoreboard;
    logic [31:0]        sq_avg [4096];
    logic signed [31:0] mom_buf [4096];
    logic [15:0]        lr, alpha, eps, wd, mom;
    logic signed [31:0] pending [$];
    int                 mismatches;

    function new();
      foreach (sq_avg[i]) begin
        sq_avg[i] = '0;
        mom_buf[i] = '0;
      end
      lr = LR_RST;
      alpha = ALPHA_RST;
      eps = EPS_RST;
      wd = WD_RST;
      mom = MOM_RST;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [15:0] v);
      case (r)
        REG_LEARN_RATE:   lr = v;
        REG_DECAY_ALPHA:  alpha = v;
        REG_EPSILON:      eps = v;
        REG_WD_FACTOR:    wd = v;
        REG_MOMENTUM:     mom = v;
        default: ;
      endcase
    endfunction

    function longint floor16(longint x);
      return x >>> 16;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_input(logic [11:0] idx, logic signed [31:0] grad,
                             logic signed [31:0] prm);
      longint g, stp, x, b, p;
      longint unsigned mag, gsq, avg, root, den;
      p = prm;
      g = grad;
      if (wd != 0) g = clip32(g + floor16(longint'(wd) * p));
      mag = (g < 0) ? -g : g;
      gsq = (mag * mag) >> 16;
      if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
      avg = (longint'(alpha) * sq_avg[idx] + (65536 - longint'(alpha)) * gsq) >> 16;
      if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
      sq_avg[idx] = avg[31:0];
      root = int_root(avg << 16);
      den = root + eps;
      if (den == 0) den = 1;
      stp = clip32((g * 65536) / longint'(den));
      if (mom != 0) begin
        b = floor16(longint'(mom) * longint'(mom_buf[idx])) + stp;
        mom_buf[idx] = clip32(b);
        x = mom_buf[idx];
      end else begin
        x = stp;
      end
      pending.push_back(clip32(p - floor16(longint'(lr) * x)));
    endfunction

    function void check_result(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction new_param=%0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("new_param mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [11:0] elem_index = '0;
  logic signed [31:0] gradient = '0, param_value = '0, new_param;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  int send_idle = 0, recv_stall = 0;
  update_scoreboard sb = new();

  always #4 clk = ~clk;

  rmsprop_update dut (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(new_param);
    if (!rst && in_valid && in_ready) sb.note_input(elem_index, gradient, param_value);
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // in_valid stays high after acceptance until the next idle cycle or drain
  task automatic send(logic [11:0] idx, logic signed [31:0] g, logic signed [31:0] p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    elem_index <= idx;
    gradient <= g;
    param_value <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    cfg_we <= 1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(131072)) - 65536;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(2097152)) - 1048576;
    endcase
  endfunction

  task automatic rand_items(int n);
    for (int i = 0; i < n; i++)
      send($urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(15)),
           rand_value(), rand_value());
  endtask

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed corners at reset settings
    send(12'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(12'd4095, 32'sh8000_0000, 32'sh8000_0000);
    send(12'd0, 32'sh0, 32'sh0);
    send(12'd0, 32'sh0001_0000, -32'sh0001_0000);
    send(12'd4095, -32'sd1, 32'sd1);
    drain();
    // zero denominator, full rates, momentum on
    write_reg(REG_EPSILON, 16'd0);
    write_reg(REG_LEARN_RATE, 16'd65535);
    write_reg(REG_DECAY_ALPHA, 16'd1);
    write_reg(REG_WD_FACTOR, 16'd65535);
    write_reg(REG_MOMENTUM, 16'd65535);
    send(12'd7, 32'sh0, 32'sh0);
    send(12'd7, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(12'd7, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(12'd8, 32'sh8000_0000, 32'sh8000_0000);
    send(12'd8, 32'sh8000_0000, 32'sh8000_0000);
    send(12'd9, 32'sh0000_8000, -32'sh0100_0000);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 63; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 63; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      write_reg(REG_LEARN_RATE, ph == 3 ? 16'd1 : 16'($urandom_range(65535, 1)));
      write_reg(REG_DECAY_ALPHA, ph == 5 ? 16'd65535 : 16'($urandom_range(65535, 1)));
      write_reg(REG_EPSILON, ph == 6 ? 16'd65535 : 16'($urandom_range(300)));
      write_reg(REG_WD_FACTOR, ph[0] ? 16'd0 : 16'($urandom_range(65535)));
      write_reg(REG_MOMENTUM, ph[1] ? 16'd0 : 16'($urandom_range(65535)));
      rand_items(75);
      drain();
      rand_items(75);
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
